// ----- sv/mfs_pkg.sv -----
package mfs_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] FUNC_HIDDEN_WT = 2'd0;
   localparam logic [1:0] FUNC_OUTPUT_WT = 2'd1;
   localparam logic [1:0] FUNC_INPUT     = 2'd2;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
   localparam logic [1:0] REG_HIDDEN_COUNT = 2'd1;
   localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

   // Reset values of the count registers
   localparam logic [6:0] INPUT_COUNT_RST  = 7'd64;
   localparam logic [6:0] HIDDEN_COUNT_RST = 7'd64;
   localparam logic [4:0] OUTPUT_COUNT_RST = 5'd10;

   // Most classes reported in one run
   localparam int OutCap = 16;

   // Sigmoid at 0, 0.5, ..., 8.0 in Q0.16
   function automatic logic [16:0] sig_tab(input logic [4:0] idx);
      logic [16:0] v;
      case (idx)
         5'd0:    v = 17'd32768;
         5'd1:    v = 17'd40793;
         5'd2:    v = 17'd47911;
         5'd3:    v = 17'd53581;
         5'd4:    v = 17'd57724;
         5'd5:    v = 17'd60565;
         5'd6:    v = 17'd62428;
         5'd7:    v = 17'd63615;
         5'd8:    v = 17'd64357;
         5'd9:    v = 17'd64816;
         5'd10:   v = 17'd65097;
         5'd11:   v = 17'd65269;
         5'd12:   v = 17'd65374;
         5'd13:   v = 17'd65437;
         5'd14:   v = 17'd65476;
         5'd15:   v = 17'd65500;
         default: v = 17'd65514;
      endcase
      return v;
   endfunction

   // e^(k/16) in Q2.16
   function automatic logic [17:0] exp_tab(input logic [4:0] idx);
      logic [17:0] v;
      case (idx)
         5'd0:    v = 18'd65536;
         5'd1:    v = 18'd69763;
         5'd2:    v = 18'd74262;
         5'd3:    v = 18'd79052;
         5'd4:    v = 18'd84150;
         5'd5:    v = 18'd89577;
         5'd6:    v = 18'd95354;
         5'd7:    v = 18'd101504;
         5'd8:    v = 18'd108051;
         5'd9:    v = 18'd115019;
         5'd10:   v = 18'd122437;
         5'd11:   v = 18'd130334;
         5'd12:   v = 18'd138740;
         5'd13:   v = 18'd147688;
         5'd14:   v = 18'd157213;
         5'd15:   v = 18'd167352;
         default: v = 18'd178145;
      endcase
      return v;
   endfunction

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic       load_wr;    // store the accepted request item
      logic       mac_issue;  // read one weight/operand pair
      logic       mac_first;  // first pair of a neuron: restart the sum
      logic       layer_out;  // output layer operands
      logic [5:0] row;
      logic [5:0] col;
      logic       hid_wr;     // write hidden activation at row
      logic       exp_wr;     // write exp value at cls, add to total
      logic       tot_clr;
      logic       div_load;
      logic       div_step;
      logic [3:0] cls;
   } dp_cmd_type;

endpackage

// ----- sv/mfs_csr.sv -----
module mfs_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [6:0]  input_count,
   output logic [6:0]  hidden_count,
   output logic [4:0]  output_count
);

   logic [6:0] in_cnt_ff, hid_cnt_ff;
   logic [4:0] out_cnt_ff;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= mfs_pkg::INPUT_COUNT_RST;
         hid_cnt_ff <= mfs_pkg::HIDDEN_COUNT_RST;
         out_cnt_ff <= mfs_pkg::OUTPUT_COUNT_RST;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            mfs_pkg::REG_INPUT_COUNT:  in_cnt_ff  <= csr_pwdata[6:0];
            mfs_pkg::REG_HIDDEN_COUNT: hid_cnt_ff <= csr_pwdata[6:0];
            mfs_pkg::REG_OUTPUT_COUNT: out_cnt_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         mfs_pkg::REG_INPUT_COUNT:  csr_prdata = {25'd0, in_cnt_ff};
         mfs_pkg::REG_HIDDEN_COUNT: csr_prdata = {25'd0, hid_cnt_ff};
         mfs_pkg::REG_OUTPUT_COUNT: csr_prdata = {27'd0, out_cnt_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   assign input_count  = in_cnt_ff;
   assign hidden_count = hid_cnt_ff;
   assign output_count = out_cnt_ff;

endmodule

// ----- sv/mfs_dp.sv -----
module mfs_dp #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_HIDDEN  = 64,
   parameter int MAX_OUTPUTS = 16,
   parameter int FRAC_BITS   = 12
) (
   input  logic                clock,
   input  mfs_pkg::dp_cmd_type cmd,
   input  logic [1:0]          req_func,
   input  logic [5:0]          req_row,
   input  logic [5:0]          req_col,
   input  logic signed [15:0]  req_value,
   output logic [15:0]         prob
);

   localparam int FW     = FRAC_BITS - 1;
   // Rows past the class limit are never read, so the store holds only those in use
   localparam int OwRows = (MAX_OUTPUTS < mfs_pkg::OutCap) ? MAX_OUTPUTS : mfs_pkg::OutCap;

   logic signed [15:0] hw_mem [0:4095];
   logic signed [15:0] ow_mem [0:1023];
   logic signed [15:0] iv_mem [0:63];
   logic signed [15:0] ha_mem [0:63];
   logic [17:0]        exp_mem [0:15];

   // Item stores
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         case (req_func)
            mfs_pkg::FUNC_HIDDEN_WT:
               if (int'(req_row) < MAX_HIDDEN && int'(req_col) < MAX_INPUTS)
                  hw_mem[{req_row, req_col}] <= req_value;
            mfs_pkg::FUNC_OUTPUT_WT:
               if (int'(req_row) < OwRows && int'(req_col) < MAX_HIDDEN)
                  ow_mem[{req_row[3:0], req_col}] <= req_value;
            mfs_pkg::FUNC_INPUT:
               if (int'(req_col) < MAX_INPUTS)
                  iv_mem[req_col] <= req_value;
            default: ;
         endcase
      end
   end

   // Multiply-accumulate pipeline: read, multiply, add
   logic signed [15:0] hw_rd_ff, ow_rd_ff, iv_rd_ff, ha_rd_ff;
   logic               v1_ff, first1_ff, layer1_ff;
   logic signed [31:0] prod_ff;
   logic               v2_ff, first2_ff;
   logic signed [39:0] acc_ff;
   logic signed [15:0] w_sel, x_sel;

   always_ff @(posedge clock) begin
      hw_rd_ff <= hw_mem[{cmd.row, cmd.col}];
      ow_rd_ff <= ow_mem[{cmd.row[3:0], cmd.col}];
      iv_rd_ff <= iv_mem[cmd.col];
      ha_rd_ff <= ha_mem[cmd.col];
   end

   assign w_sel = layer1_ff ? ow_rd_ff : hw_rd_ff;
   assign x_sel = layer1_ff ? ha_rd_ff : iv_rd_ff;

   always_ff @(posedge clock) begin
      v1_ff     <= cmd.mac_issue;
      first1_ff <= cmd.mac_first;
      layer1_ff <= cmd.layer_out;
      prod_ff   <= w_sel * x_sel;
      v2_ff     <= v1_ff;
      first2_ff <= first1_ff;
      if (v2_ff)
         acc_ff <= (first2_ff ? 40'sd0 : acc_ff) + 40'(prod_ff);
   end

   // Sigmoid: clamp and split, interpolate, fold sign
   localparam logic signed [39:0] Lim = 40'sd8 <<< FRAC_BITS;
   logic signed [39:0] z, zc;
   logic [19:0]        a_abs;
   logic [4:0]         sg_idx, sg_idx_ff;
   logic [FW-1:0]      sg_frac_ff;
   logic               sg_neg_ff, sg_neg2_ff;
   logic [16:0]        sg_base, sg_base_ff, sg_diff;
   logic [31:0]        sg_prod_ff;
   logic [16:0]        sg_sum, s_ff;

   always_comb begin
      z = acc_ff >>> FRAC_BITS;
      if (z > Lim)
         zc = Lim;
      else if (z < -Lim)
         zc = -Lim;
      else
         zc = z;
      a_abs  = zc[39] ? 20'(-zc) : zc[19:0];
      sg_idx = 5'(a_abs >> FW);
   end

   always_comb begin
      sg_base = mfs_pkg::sig_tab(sg_idx_ff);
      sg_diff = (sg_idx_ff >= 5'd16) ? 17'd0
                                      : mfs_pkg::sig_tab(sg_idx_ff + 5'd1) - sg_base;
      sg_sum  = sg_base_ff + 17'(sg_prod_ff >> FW);
   end

   always_ff @(posedge clock) begin
      sg_idx_ff  <= sg_idx;
      sg_frac_ff <= a_abs[FW-1:0];
      sg_neg_ff  <= zc[39];
      sg_base_ff <= sg_base;
      sg_prod_ff <= 32'(sg_diff * sg_frac_ff);
      sg_neg2_ff <= sg_neg_ff;
      s_ff       <= sg_neg2_ff ? 17'd65536 - sg_sum : sg_sum;
   end

   // Hidden activation: round to FRAC_BITS, saturate
   logic [17:0] h_sum, h_shift;
   logic [15:0] h_val;

   always_comb begin
      h_sum   = {1'b0, s_ff} + (18'd1 << (15 - FRAC_BITS));
      h_shift = h_sum >> (16 - FRAC_BITS);
      h_val   = (h_shift > 18'd32767) ? 16'd32767 : h_shift[15:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.hid_wr)
         ha_mem[cmd.row] <= h_val;
   end

   // Exponential by table and interpolation
   logic [17:0] ex_base, ex_base_ff, ex_diff, ex_val;
   logic [29:0] ex_prod_ff;
   logic [22:0] tot_ff;

   always_comb begin
      ex_base = mfs_pkg::exp_tab(s_ff[16:12]);
      ex_diff = (s_ff[16:12] >= 5'd16) ? 18'd0
                                        : mfs_pkg::exp_tab(s_ff[16:12] + 5'd1) - ex_base;
      ex_val  = ex_base_ff + 18'(ex_prod_ff >> 12);
   end

   always_ff @(posedge clock) begin
      ex_base_ff <= ex_base;
      ex_prod_ff <= 30'(ex_diff * s_ff[11:0]);
      if (cmd.exp_wr)
         exp_mem[cmd.cls] <= ex_val;
      if (cmd.tot_clr)
         tot_ff <= 23'd0;
      else if (cmd.exp_wr)
         tot_ff <= tot_ff + 23'(ex_val);
   end

   // Restoring divider, one quotient bit per step
   logic [23:0] rem_ff;
   logic [16:0] q_ff;
   logic        ge;
   logic [23:0] rem_sub;

   assign ge      = rem_ff >= {1'b0, tot_ff};
   assign rem_sub = ge ? rem_ff - {1'b0, tot_ff} : rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= {6'd0, exp_mem[cmd.cls]};
         q_ff   <= 17'd0;
      end else if (cmd.div_step) begin
         rem_ff <= {rem_sub[22:0], 1'b0};
         q_ff   <= {q_ff[15:0], ge};
      end
   end

   assign prob = q_ff[16] ? 16'hFFFF : q_ff[15:0];

endmodule

// ----- sv/mfs_ctrl.sv -----
module mfs_ctrl #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_HIDDEN  = 64,
   parameter int MAX_OUTPUTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [1:0]          req_func,
   input  logic                req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic                rsp_tlast,
   output logic [3:0]          rsp_class,
   input  logic [6:0]          input_count,
   input  logic [6:0]          hidden_count,
   input  logic [4:0]          output_count,
   output mfs_pkg::dp_cmd_type cmd
);

   localparam int NiCap = (MAX_INPUTS < 64) ? MAX_INPUTS : 64;
   localparam int NhCap = (MAX_HIDDEN < 64) ? MAX_HIDDEN : 64;
   localparam int NoCap = (MAX_OUTPUTS < mfs_pkg::OutCap) ? MAX_OUTPUTS : mfs_pkg::OutCap;

   localparam logic [4:0] HidWrAt = 5'd5;
   localparam logic [4:0] ExpWrAt = 5'd6;
   localparam logic [4:0] DivEnd  = 5'd17;

   typedef enum logic [2:0] {
      IDLE, HMAC, HACT, OMAC, OACT, DIV, RESP
   } state_type;

   state_type  state_ff;
   logic [5:0] i_ff, j_ff;
   logic [3:0] k_ff;
   logic [4:0] cnt_ff;
   logic [6:0] ni_ff, nh_ff;
   logic [4:0] no_ff;
   logic       vld_ff, last_ff;
   logic [3:0] cls_ff;
   logic       accept, start;
   logic       i_last_in, i_last_hid, j_last, k_last;

   assign req_tready = (state_ff == IDLE);
   assign accept     = req_tvalid & req_tready;
   assign start      = accept && (req_func == mfs_pkg::FUNC_INPUT) && req_tlast;
   assign i_last_in  = ({1'b0, i_ff} == ni_ff - 7'd1);
   assign i_last_hid = ({1'b0, i_ff} == nh_ff - 7'd1);
   assign j_last     = ({1'b0, j_ff} == nh_ff - 7'd1);
   assign k_last     = ({1'b0, k_ff} == no_ff - 5'd1);

   always_comb begin
      cmd           = '0;
      cmd.load_wr   = accept;
      cmd.tot_clr   = start;
      cmd.cls       = k_ff;
      case (state_ff)
         HMAC: begin
            cmd.mac_issue = 1'b1;
            cmd.mac_first = (i_ff == 6'd0);
            cmd.row       = j_ff;
            cmd.col       = i_ff;
         end
         HACT: begin
            cmd.row    = j_ff;
            cmd.hid_wr = (cnt_ff == HidWrAt);
         end
         OMAC: begin
            cmd.mac_issue = 1'b1;
            cmd.mac_first = (i_ff == 6'd0);
            cmd.layer_out = 1'b1;
            cmd.row       = {2'b00, k_ff};
            cmd.col       = i_ff;
         end
         OACT: cmd.exp_wr = (cnt_ff == ExpWrAt);
         DIV: begin
            cmd.div_load = (cnt_ff == 5'd0);
            cmd.div_step = (cnt_ff != 5'd0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         vld_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         cnt_ff   <= '0;
         ni_ff    <= 7'd1;
         nh_ff    <= 7'd1;
         no_ff    <= 5'd1;
         last_ff  <= 1'b0;
         cls_ff   <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (start) begin
                  // Latch effective counts for the whole run
                  ni_ff <= (input_count == 7'd0) ? 7'd1 :
                           (int'(input_count) > NiCap) ? 7'(NiCap) : input_count;
                  nh_ff <= (hidden_count == 7'd0) ? 7'd1 :
                           (int'(hidden_count) > NhCap) ? 7'(NhCap) : hidden_count;
                  no_ff <= (output_count == 5'd0) ? 5'd1 :
                           (int'(output_count) > NoCap) ? 5'(NoCap) : output_count;
                  i_ff     <= '0;
                  j_ff     <= '0;
                  state_ff <= HMAC;
               end
            end
            HMAC: begin
               if (i_last_in) begin
                  cnt_ff   <= '0;
                  state_ff <= HACT;
               end else begin
                  i_ff <= i_ff + 6'd1;
               end
            end
            HACT: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == HidWrAt) begin
                  i_ff <= '0;
                  if (j_last) begin
                     k_ff     <= '0;
                     state_ff <= OMAC;
                  end else begin
                     j_ff     <= j_ff + 6'd1;
                     state_ff <= HMAC;
                  end
               end
            end
            OMAC: begin
               if (i_last_hid) begin
                  cnt_ff   <= '0;
                  state_ff <= OACT;
               end else begin
                  i_ff <= i_ff + 6'd1;
               end
            end
            OACT: begin
               if (cnt_ff == ExpWrAt) begin
                  i_ff   <= '0;
                  cnt_ff <= '0;
                  if (k_last) begin
                     k_ff     <= '0;
                     state_ff <= DIV;
                  end else begin
                     k_ff     <= k_ff + 4'd1;
                     state_ff <= OMAC;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            DIV: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == DivEnd) begin
                  vld_ff   <= 1'b1;
                  last_ff  <= k_last;
                  cls_ff   <= k_ff;
                  state_ff <= RESP;
               end
            end
            RESP: begin
               if (rsp_tready) begin
                  vld_ff <= 1'b0;
                  cnt_ff <= '0;
                  if (last_ff) begin
                     state_ff <= IDLE;
                  end else begin
                     k_ff     <= k_ff + 4'd1;
                     state_ff <= DIV;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_class  = cls_ff;

endmodule

// ----- sv/mlp_forward_sigmoid_softmax.sv -----
// Channel   Dir  Handshake              Payload
// req_*     in   req_tvalid/req_tready  tdata: func, row, col, value; tlast: last_in
// rsp_*     out  rsp_tvalid/rsp_tready  tdata: prob, class_index; tlast: last_out
// csr_*     in   APB psel/penable       input_count, hidden_count, output_count
//
// Weight and element beats are stored as they are accepted. A beat with tlast on an
// element runs the pass: each hidden neuron and then each class goes through the
// shared multiply-accumulate unit and its activation, then for each class the
// bit-serial divider forms the probability and the result is handed over.
// req_tready is low for the whole pass. A stalled result holds in the output
// register. Synchronous reset acts only on the sequencer and the count registers.
module mlp_forward_sigmoid_softmax #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_HIDDEN  = 64,
   parameter int MAX_OUTPUTS = 16,
   parameter int FRAC_BITS   = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // func[1:0], row[7:2], col[13:8], value[29:14]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // prob[15:0], class_index[19:16]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   mfs_pkg::dp_cmd_type cmd;
   logic [6:0]  input_count, hidden_count;
   logic [4:0]  output_count;
   logic [15:0] prob;
   logic [3:0]  class_index;

   mfs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .input_count  (input_count),
      .hidden_count (hidden_count),
      .output_count (output_count)
   );

   // Sequencer: walks neurons, classes and divider steps
   mfs_ctrl #(
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_HIDDEN  (MAX_HIDDEN),
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_func     (req_tdata[1:0]),
      .req_tlast    (req_tlast),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tlast    (rsp_tlast),
      .rsp_class    (class_index),
      .input_count  (input_count),
      .hidden_count (hidden_count),
      .output_count (output_count),
      .cmd          (cmd)
   );

   // Weight stores, MAC, sigmoid/exp tables and divider
   mfs_dp #(
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_HIDDEN  (MAX_HIDDEN),
      .MAX_OUTPUTS (MAX_OUTPUTS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .req_func  (req_tdata[1:0]),
      .req_row   (req_tdata[7:2]),
      .req_col   (req_tdata[13:8]),
      .req_value (req_tdata[29:14]),
      .prob      (prob)
   );

   assign rsp_tdata = {4'd0, class_index, prob};

endmodule
